// ===== sv/ohlc_pkg.sv =====
// shared types, widths and helpers for the ohlc bar aggregator
package ohlc_pkg;

  localparam int TIME_W   = 40;
  localparam int PRICE_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60);
  localparam logic [TIME_W-1:0]   START_RESET  = '0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = CFG_IDX_W'(1);

  // item modes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [TIME_W-1:0]  tick_time;
    logic [PRICE_W-1:0] bid_price;
    logic               bid_ok;
    logic [PRICE_W-1:0] ask_price;
    logic               ask_ok;
    logic [TIME_W-1:0]  period_end;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0]  bar_end;
    logic [PRICE_W-1:0] bid_open;
    logic [PRICE_W-1:0] bid_high;
    logic [PRICE_W-1:0] bid_low;
    logic [PRICE_W-1:0] bid_close;
    logic               bid_fields_ok;
    logic [PRICE_W-1:0] ask_open;
    logic [PRICE_W-1:0] ask_high;
    logic [PRICE_W-1:0] ask_low;
    logic [PRICE_W-1:0] ask_close;
    logic               ask_fields_ok;
  } out_t;

  // classified work passed from front to back
  typedef struct packed {
    logic               is_close;
    logic [PRICE_W-1:0] bid_price;
    logic               bid_ok;
    logic [PRICE_W-1:0] ask_price;
    logic               ask_ok;
    logic [TIME_W-1:0]  period_end;
  } op_t;

  typedef struct packed {
    logic [PRICE_W-1:0] open;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] close;
  } agg_t;

  // fold one price into a running bar
  function automatic agg_t agg_update(agg_t a, logic ok, logic [PRICE_W-1:0] x);
    agg_t r;
    r = a;
    if (!ok) begin
      r.open = x;
      r.high = x;
      r.low = x;
      r.close = x;
    end else begin
      if (x > a.high) r.high = x;
      if (x < a.low) r.low = x;
      r.close = x;
    end
    return r;
  endfunction

endpackage

// ===== sv/ohlc_front.sv =====
// front end: config registers, accept threshold unit, tick filtering
module ohlc_front import ohlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 back_idle,
  input  logic                 push,
  input  in_t                  item,
  output logic                 busy,
  output logic                 op_valid,
  output op_t                  op
);

  typedef enum logic [1:0] {S_LOAD, S_DIV, S_FIN, S_IDLE} state_t;

  localparam int CNT_W = $clog2(TIME_W + 1);

  state_t               state;
  logic [PERIOD_W-1:0]  period_length;
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W-1:0]    ts;
  logic                 neg;
  logic [PERIOD_W-1:0]  per;
  logic [TIME_W-1:0]    dvd;
  logic [PERIOD_W-1:0]  rem;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_W-1:0]    accept_after;
  logic                 accept_below;

  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W-1:0]  m_val;
  logic [PERIOD_W-1:0]  d_val;
  logic [TIME_W-1:0]    d_ext;
  logic                 take;

  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  // one quotient bit per cycle
  assign trial = {rem, dvd[TIME_W-1]};

  // floor remainder and distance back to the previous period end
  always_comb begin
    m_val = (neg && rem != '0) ? per - rem : rem;
    d_val = (m_val == '0) ? per : m_val;
    d_ext = {{(TIME_W-PERIOD_W){1'b0}}, d_val};
  end

  // threshold sequencer and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      period_length <= PERIOD_RESET;
      start_time <= START_RESET;
    end else begin
      case (state)
        S_LOAD: begin
          ts <= start_time;
          neg <= start_time[TIME_W-1];
          dvd <= start_time[TIME_W-1] ? TIME_W'(-start_time) : start_time;
          per <= (period_length == '0) ? PERIOD_W'(1) : period_length;
          rem <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= (trial >= {1'b0, per}) ? PERIOD_W'(trial - {1'b0, per})
                                         : trial[PERIOD_W-1:0];
          dvd <= {dvd[TIME_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(TIME_W - 1)) state <= S_FIN;
        end
        S_FIN: begin
          accept_below <= (ts ^ {1'b1, {(TIME_W-1){1'b0}}}) < d_ext;
          accept_after <= ts - d_ext;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_PERIOD_LENGTH) begin
              period_length <= cfg_data[PERIOD_W-1:0];
              if (back_idle) state <= S_LOAD;
            end else if (cfg_index == REG_START_TIME) begin
              start_time <= cfg_data;
              if (back_idle) state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // classify the item; dropped ticks never reach the back end
  assign take = accept_below || ($signed(item.tick_time) > $signed(accept_after));
  assign op_valid = push && !busy && (item.mode == MODE_CLOSE || take);

  always_comb begin
    op.is_close = (item.mode == MODE_CLOSE);
    op.bid_price = item.bid_price;
    op.bid_ok = item.bid_ok;
    op.ask_price = item.ask_price;
    op.ask_ok = item.ask_ok;
    op.period_end = item.period_end;
  end

endmodule

// ===== sv/ohlc_fifo.sv =====
// two-entry queue between front and back
module ohlc_fifo import ohlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  op_t  wdata,
  output logic full,
  input  logic rd,
  output logic nempty,
  output op_t  rdata
);

  op_t        mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign nempty = (count != 2'd0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== sv/ohlc_back.sv =====
// back end: running bars, close handling and the result register
module ohlc_back import ohlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  op_t  op,
  output logic op_take,
  output logic back_idle,
  input  logic pop,
  output logic empty,
  output out_t result
);

  logic               bucket_used;
  agg_t               bid_agg;
  agg_t               ask_agg;
  logic               bid_agg_ok;
  logic               ask_agg_ok;
  logic               have_last_close;
  logic [PRICE_W-1:0] last_bid;
  logic [PRICE_W-1:0] last_ask;
  logic               last_bid_ok;
  logic               last_ask_ok;
  logic               out_valid;
  logic               slot_free;

  assign empty = !out_valid;
  assign back_idle = !bucket_used && !have_last_close;
  assign slot_free = !out_valid || pop;
  assign op_take = op_valid && (!op.is_close || slot_free);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_used <= 1'b0;
      bid_agg_ok <= 1'b0;
      ask_agg_ok <= 1'b0;
      have_last_close <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (op_take) begin
        if (!op.is_close) begin
          bucket_used <= 1'b1;
          if (op.bid_ok) bid_agg_ok <= 1'b1;
          if (op.ask_ok) ask_agg_ok <= 1'b1;
        end else if (bucket_used) begin
          out_valid <= 1'b1;
          have_last_close <= 1'b1;
          bucket_used <= 1'b0;
          bid_agg_ok <= 1'b0;
          ask_agg_ok <= 1'b0;
        end else if (have_last_close) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // payload: bars, remembered closes and the emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_bid <= '0;
      last_ask <= '0;
      last_bid_ok <= 1'b0;
      last_ask_ok <= 1'b0;
    end else if (op_take) begin
      if (!op.is_close) begin
        if (op.bid_ok) bid_agg <= agg_update(bid_agg, bid_agg_ok, op.bid_price);
        if (op.ask_ok) ask_agg <= agg_update(ask_agg, ask_agg_ok, op.ask_price);
      end else if (bucket_used) begin
        result.bar_end <= op.period_end;
        result.bid_open <= bid_agg_ok ? bid_agg.open : '0;
        result.bid_high <= bid_agg_ok ? bid_agg.high : '0;
        result.bid_low <= bid_agg_ok ? bid_agg.low : '0;
        result.bid_close <= bid_agg_ok ? bid_agg.close : '0;
        result.bid_fields_ok <= bid_agg_ok;
        result.ask_open <= ask_agg_ok ? ask_agg.open : '0;
        result.ask_high <= ask_agg_ok ? ask_agg.high : '0;
        result.ask_low <= ask_agg_ok ? ask_agg.low : '0;
        result.ask_close <= ask_agg_ok ? ask_agg.close : '0;
        result.ask_fields_ok <= ask_agg_ok;
        last_bid <= bid_agg_ok ? bid_agg.close : '0;
        last_ask <= ask_agg_ok ? ask_agg.close : '0;
        last_bid_ok <= bid_agg_ok;
        last_ask_ok <= ask_agg_ok;
      end else if (have_last_close) begin
        // flat bar at the remembered closes
        result.bar_end <= op.period_end;
        result.bid_open <= last_bid;
        result.bid_high <= last_bid;
        result.bid_low <= last_bid;
        result.bid_close <= last_bid;
        result.bid_fields_ok <= last_bid_ok;
        result.ask_open <= last_ask;
        result.ask_high <= last_ask;
        result.ask_low <= last_ask;
        result.ask_close <= last_ask;
        result.ask_fields_ok <= last_ask_ok;
      end
    end
  end

endmodule

// ===== sv/ohlc_bar_aggregator.sv =====
// top level: one tick or close per cycle while full is low
// a close result passes the queue and the result register before reaching the result ports
// closes are limited by the single result register and wait until it is free or popped
// reset: threshold unit runs load, divide and finish (full held high) before items are taken
// each accepted config write restarts that computation if no bar is open and no close is held
module ohlc_bar_aggregator import ohlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_t                  item,
  input  logic                 pop,
  output logic                 empty,
  output out_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  logic busy;
  logic back_idle;
  logic f_valid;
  op_t  f_op;
  logic q_full;
  logic q_nempty;
  op_t  q_op;
  logic q_take;

  assign full = busy || q_full;

  // front: filtering and threshold
  ohlc_front u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .back_idle(back_idle),
    .push(push && !q_full), .item(item),
    .busy(busy), .op_valid(f_valid), .op(f_op)
  );

  // decoupling queue
  ohlc_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr(f_valid), .wdata(f_op), .full(q_full),
    .rd(q_take), .nempty(q_nempty), .rdata(q_op)
  );

  // back: aggregation and result
  ohlc_back u_back (
    .clk(clk), .rst(rst),
    .op_valid(q_nempty), .op(q_op), .op_take(q_take),
    .back_idle(back_idle),
    .pop(pop), .empty(empty), .result(result)
  );

endmodule

// ===== bench/ohlc_checker.sv =====
// scoreboard for the ohlc bar aggregator: tracks bars and compares every result transaction
`timescale 1ns / 1ps
module ohlc_checker import ohlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  in_t                  item,
  input  logic                 pop,
  input  logic                 empty,
  input  out_t                 result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output int                   pending,
  output int                   errors
);

  // tracked copy of the block state
  logic [PERIOD_W-1:0] period_q;
  logic [TIME_W-1:0]   start_q;
  longint              gate_time;
  bit                  gate_open_all;
  bit                  bar_busy;
  bit                  have_close;
  agg_t                bid_bar, ask_bar;
  bit                  bid_bar_ok, ask_bar_ok;
  logic [PRICE_W:0]    held_bid, held_ask;
  out_t                bar_q[$];

  // first period end minus one period, with floor rounding
  function automatic void update_gate();
    longint p, ts, tmin, m, d;
    p = (period_q == 0) ? 1 : longint'(period_q);
    ts = longint'(signed'(start_q));
    tmin = -(longint'(1) << (TIME_W - 1));
    m = ts % p;
    if (m < 0) m += p;
    d = (m == 0) ? p : m;
    if (ts - tmin < d) begin
      gate_open_all = 1;
      gate_time = tmin;
    end else begin
      gate_open_all = 0;
      gate_time = ts - d;
    end
  endfunction

  function automatic agg_t fold_price(agg_t a, bit ok, logic [PRICE_W-1:0] x);
    agg_t r;
    r = a;
    if (!ok) begin
      r = '{x, x, x, x};
    end else begin
      if (x > r.high) r.high = x;
      if (x < r.low) r.low = x;
      r.close = x;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_t bar, want;
    longint t;
    if (rst) begin
      period_q = PERIOD_RESET;
      start_q = START_RESET;
      bar_busy = 0;
      have_close = 0;
      bid_bar = '0;
      ask_bar = '0;
      bid_bar_ok = 0;
      ask_bar_ok = 0;
      held_bid = '0;
      held_ask = '0;
      bar_q.delete();
      errors = 0;
      update_gate();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PERIOD_LENGTH) period_q = cfg_data[PERIOD_W-1:0];
        else if (cfg_index == REG_START_TIME) start_q = cfg_data;
        if (!bar_busy && !have_close) update_gate();
      end
      // result transaction
      if (pop && !empty) begin
        if (bar_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          errors++;
        end else begin
          want = bar_q.pop_front();
          check_field("bar_end", 64'(want.bar_end), 64'(result.bar_end));
          check_field("bid_open", 64'(want.bid_open), 64'(result.bid_open));
          check_field("bid_high", 64'(want.bid_high), 64'(result.bid_high));
          check_field("bid_low", 64'(want.bid_low), 64'(result.bid_low));
          check_field("bid_close", 64'(want.bid_close), 64'(result.bid_close));
          check_field("bid_fields_ok", 64'(want.bid_fields_ok), 64'(result.bid_fields_ok));
          check_field("ask_open", 64'(want.ask_open), 64'(result.ask_open));
          check_field("ask_high", 64'(want.ask_high), 64'(result.ask_high));
          check_field("ask_low", 64'(want.ask_low), 64'(result.ask_low));
          check_field("ask_close", 64'(want.ask_close), 64'(result.ask_close));
          check_field("ask_fields_ok", 64'(want.ask_fields_ok), 64'(result.ask_fields_ok));
        end
      end
      // input transaction
      if (push && !full) begin
        if (item.mode == MODE_TICK) begin
          t = longint'(signed'(item.tick_time));
          if (gate_open_all || t > gate_time) begin
            if (item.bid_ok) begin
              bid_bar = fold_price(bid_bar, bid_bar_ok, item.bid_price);
              bid_bar_ok = 1;
            end
            if (item.ask_ok) begin
              ask_bar = fold_price(ask_bar, ask_bar_ok, item.ask_price);
              ask_bar_ok = 1;
            end
            bar_busy = 1;
          end
        end else if (bar_busy) begin
          bar = '0;
          bar.bar_end = item.period_end;
          if (bid_bar_ok) begin
            {bar.bid_open, bar.bid_high, bar.bid_low, bar.bid_close} = bid_bar;
            bar.bid_fields_ok = 1;
          end
          if (ask_bar_ok) begin
            {bar.ask_open, bar.ask_high, bar.ask_low, bar.ask_close} = ask_bar;
            bar.ask_fields_ok = 1;
          end
          held_bid = bid_bar_ok ? {1'b1, bid_bar.close} : '0;
          held_ask = ask_bar_ok ? {1'b1, ask_bar.close} : '0;
          have_close = 1;
          bar_busy = 0;
          bid_bar_ok = 0;
          ask_bar_ok = 0;
          bar_q.insert(bar_q.size(), bar);
        end else if (have_close) begin
          // flat bar at the remembered closes
          bar = '0;
          bar.bar_end = item.period_end;
          if (held_bid[PRICE_W]) begin
            {bar.bid_open, bar.bid_high, bar.bid_low, bar.bid_close} = {4{held_bid[PRICE_W-1:0]}};
            bar.bid_fields_ok = 1;
          end
          if (held_ask[PRICE_W]) begin
            {bar.ask_open, bar.ask_high, bar.ask_low, bar.ask_close} = {4{held_ask[PRICE_W-1:0]}};
            bar.ask_fields_ok = 1;
          end
          bar_q.insert(bar_q.size(), bar);
        end
      end
    end
    pending = bar_q.size();
  end

endmodule

// ===== bench/tb_ohlc_bar_aggregator.sv =====
// testbench top for the ohlc bar aggregator: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_ohlc_bar_aggregator;
  import ohlc_pkg::*;

  localparam longint TMAX = (longint'(1) << (TIME_W - 1)) - 1;
  localparam longint TMIN = -(longint'(1) << (TIME_W - 1));

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_t                  item;
  logic                 pop;
  logic                 empty;
  out_t                 result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;
  int                   pending;
  int                   errors;
  bit                   calm;
  int                   pop_hold;

  ohlc_bar_aggregator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ohlc_checker bar_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("ohlc_bar_aggregator test failed");
    $finish;
  end

  // result side with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop <= 0;
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 0;
      pop_hold <= $urandom_range(0, 4);
    end else begin
      pop <= 1;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PRICE_W'($urandom);
    endcase
  endfunction

  function automatic in_t quote(longint t, logic [PRICE_W-1:0] bp, bit bok,
                                logic [PRICE_W-1:0] ap, bit aok);
    in_t x;
    x.mode = MODE_TICK;
    x.tick_time = TIME_W'(t);
    x.bid_price = bp;
    x.bid_ok = bok;
    x.ask_price = ap;
    x.ask_ok = aok;
    x.period_end = rand_time();
    return x;
  endfunction

  function automatic in_t period_close(longint pe);
    in_t x;
    x = quote(longint'(signed'(rand_time())), rand_price(), 1'($urandom_range(0, 1)),
              rand_price(), 1'($urandom_range(0, 1)));
    x.mode = MODE_CLOSE;
    x.period_end = TIME_W'(pe);
    return x;
  endfunction

  // one input transaction, push stays high for the next one
  task automatic send(in_t x);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1;
    item <= x;
    do @(posedge clk); while (full);
  endtask

  // register write once all bars are out and the pipeline is quiet
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    push <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_regs(longint p, longint st);
    write_reg(REG_PERIOD_LENGTH, TIME_W'(p));
    write_reg(REG_START_TIME, TIME_W'(st));
  endtask

  initial begin
    longint t;
    in_t x;
    rst = 1;
    push = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = REG_PERIOD_LENGTH;
    cfg_data = '0;
    calm = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // idle settings: ticks at the threshold are dropped, closes give nothing
    send(period_close(0));
    send(quote(-60, '1, 1, '1, 1));
    send(period_close(60));
    set_regs(1, TMAX);
    send(quote(TMAX - 1, 16'h1234, 1, 16'h4321, 1));
    send(period_close(TMAX));
    set_regs(1048575, 0);
    send(quote(-1048575, 16'h0001, 1, 16'h0002, 1));
    send(period_close(0));
    set_regs(0, 5);
    send(quote(4, 16'h00ff, 1, 16'hff00, 1));
    send(period_close(5));
    set_regs(7, TMIN);
    send(period_close(TMIN));
    set_regs(60, -100);

    // directed: threshold now -120
    send(quote(-120, '1, 1, '1, 1));
    send(period_close(-60));
    send(quote(-119, '1, 1, '0, 1));
    send(quote(0, '0, 1, '1, 1));
    send(quote(5, 16'h8000, 0, 16'h7fff, 1));
    send(quote(TMAX, 16'h5555, 1, 16'haaaa, 0));
    send(period_close(0));
    send(period_close(60));
    send(quote(100, '1, 0, '1, 0));
    send(period_close(120));
    send(period_close(TMAX));
    send(quote(130, 16'h0f0f, 1, 16'h0, 0));
    send(period_close(TMIN));
    send(quote(TMIN, '1, 1, '1, 1));
    send(period_close(180));

    // random quote streams with closes, and register writes while the threshold is frozen
    for (int n = 0; n < 680; n++) begin
      if (n == 250) set_regs(longint'($urandom_range(0, 1048575)),
                             longint'(signed'(rand_time())));
      if (n == 450) set_regs(1048575, TMIN);
      if (n == 580) calm = 1;
      if ($urandom_range(0, 5) == 0) begin
        x = period_close(longint'(signed'(rand_time())));
      end else begin
        case ($urandom_range(0, 9))
          0: t = longint'(signed'(rand_time()));
          1: t = -120 - longint'($urandom_range(0, 50));
          default: t = -119 + longint'($urandom_range(0, 100000));
        endcase
        x = quote(t, rand_price(), $urandom_range(0, 3) != 0,
                  rand_price(), $urandom_range(0, 3) != 0);
      end
      send(x);
    end
    send(period_close(TMAX));
    push <= 0;

    // drain
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ohlc_bar_aggregator test passed");
    end else begin
      $display("ohlc_bar_aggregator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ohlc_pkg.sv
sv/ohlc_front.sv
sv/ohlc_fifo.sv
sv/ohlc_back.sv
sv/ohlc_bar_aggregator.sv
bench/ohlc_checker.sv
bench/tb_ohlc_bar_aggregator.sv
